>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL; the allocator top-level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SCBA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCBA_ASSERT(lbl, prop, msg)
`define SCBA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/scba_pkg.sv
// Types, constants and helpers for the size-class bucket allocator.
`timescale 1ns / 1ps
package scba_pkg;
  localparam int NUM_PAGES   = 64;
  localparam int PAGE_W      = $clog2(NUM_PAGES);
  localparam int CHAIN_W     = $clog2(NUM_PAGES + 1);
  localparam int NUM_CLASSES = 9;
  localparam int CLS_W       = 4;
  localparam int SLOT_W      = 8;
  localparam int LINK_W      = 9;
  localparam int REF_W       = 9;
  localparam int OBJ_AW      = PAGE_W + SLOT_W;
  localparam int OBJ_DEPTH   = NUM_PAGES << SLOT_W;
  localparam logic [CHAIN_W-1:0] CHAIN_NULL = CHAIN_W'(NUM_PAGES);
  localparam logic [LINK_W-1:0]  SLOT_NULL  = 9'd256;
  localparam logic [15:0]        MAX_LEN    = 16'd4096;

  localparam logic KIND_ALLOC = 1'b0;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_LARGE = 2'd1,
    STAT_NO_MEM    = 2'd2,
    STAT_BAD_ADDR  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_WALK, S_POP, S_NP, S_NP_RD, S_THREAD, S_FCHK, S_UNLINK, S_UWAIT, S_OUT
  } state_t;

  // per-page descriptor word
  typedef struct packed {
    logic [CLS_W-1:0]   cls;
    logic [REF_W-1:0]   refc;
    logic [LINK_W-1:0]  head;
    logic [CHAIN_W-1:0] nxt;
  } pg_t;

  localparam int PG_W = $bits(pg_t);

  // smallest class whose size covers len (len <= 4096)
  function automatic logic [CLS_W-1:0] get_class(input logic [15:0] len);
    logic [CLS_W-1:0] c;
    c = '0;
    for (int i = 0; i < NUM_CLASSES - 1; i++) begin
      if (len > (16'd16 << i)) c = c + 1'b1;
    end
    return c;
  endfunction
endpackage

>>> hw/rtl/scba_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module scba_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/size_class_bucket_allocator_top.sv
// Allocation: an oversize request goes straight to the result; otherwise the class chain is
// walked for a page with a free slot, then a fresh page is threaded, or out of memory results.
// Free: a page that is not live goes straight to the result; a page that empties is unlinked
// by walking its class chain from the head. One item at a time; the next is taken the cycle
// after its result is registered.
// Reset (rst, synchronous): free stack back to pages 0..N-1, no live pages, empty chains.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module size_class_bucket_allocator_top
  import scba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // request_length[15:0], free_address[33:16], size_hint[49:34]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[1:0], object_address[19:2], granted_class[23:20]
);
  state_t state, state_next;

  logic [CHAIN_W-1:0] heads [NUM_CLASSES];
  logic [NUM_PAGES-1:0] live, stk_v;
  logic [CHAIN_W-1:0] fpc;

  logic [CLS_W-1:0]   cls, cls_next;
  logic [PAGE_W-1:0]  pg, pg_next;
  logic [CHAIN_W-1:0] steps, steps_next;
  pg_t                pw, pw_next, prevw, prevw_next;
  logic [SLOT_W-1:0]  k, k_next;
  logic [PAGE_W-1:0]  stk_idx, stk_idx_next;
  logic [CHAIN_W-1:0] q, q_next, prev, prev_next, nextp, nextp_next;
  logic [17:0]        addr_r, addr_r_next;
  logic [15:0]        hint_r, hint_r_next;
  logic [1:0]         res_st, res_st_next;
  logic [17:0]        res_addr, res_addr_next;
  logic [CLS_W-1:0]   res_cls, res_cls_next;

  logic               pm_we, ob_we, sk_we;
  logic [PAGE_W-1:0]  pm_waddr, pm_raddr, sk_waddr, sk_raddr;
  pg_t                pm_wdata, pm_rdata;
  logic [OBJ_AW-1:0]  ob_waddr, ob_raddr;
  logic [LINK_W-1:0]  ob_wdata, ob_rdata;
  logic [PAGE_W-1:0]  sk_wdata, sk_rdata;
  logic [PG_W-1:0]    pm_rraw;

  // head write, live updates and stack push are decided in the data block
  logic               head_we, live_set, live_clr, push, pop;
  logic [CHAIN_W-1:0] head_wdata;
  logic [PAGE_W-1:0]  live_idx;

  scba_ram #(.W(PG_W), .D(NUM_PAGES)) u_page_ram (
    .clk, .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rraw)
  );
  assign pm_rdata = pg_t'(pm_rraw);

  scba_ram #(.W(LINK_W), .D(OBJ_DEPTH)) u_obj_ram (
    .clk, .we(ob_we), .waddr(ob_waddr), .wdata(ob_wdata),
    .raddr(ob_raddr), .rdata(ob_rdata)
  );

  scba_ram #(.W(PAGE_W), .D(NUM_PAGES)) u_stack_ram (
    .clk, .we(sk_we), .waddr(sk_waddr), .wdata(sk_wdata),
    .raddr(sk_raddr), .rdata(sk_rdata)
  );

  // input decode
  logic               in_kind, in_big;
  logic [15:0]        in_len, in_hint;
  logic [17:0]        in_addr;
  logic [CLS_W-1:0]   in_cls;
  logic [CHAIN_W-1:0] in_hp;
  logic [PAGE_W-1:0]  in_pg;

  assign in_kind = s_tuser;
  assign in_len  = s_tdata[15:0];
  assign in_addr = s_tdata[33:16];
  assign in_hint = s_tdata[49:34];
  assign in_big  = in_len > MAX_LEN;
  assign in_cls  = get_class(in_len);
  assign in_hp   = heads[in_cls];
  assign in_pg   = in_addr[17:12];

  // chain walk / free check / threading helpers
  logic               walk_hit, walk_end, f_bad, u_go, thr_last;
  logic [CHAIN_W-1:0] steps_inc;
  logic [CLS_W-1:0]   fc;
  logic [12:0]        fsz;
  logic [REF_W-1:0]   f_ref;
  logic [LINK_W-1:0]  n_obj, thr_link, first_link;
  logic [SLOT_W-1:0]  thr_slot;

  assign walk_hit  = pm_rdata.head < SLOT_NULL;
  assign steps_inc = steps + 1'b1;
  assign walk_end  = (pm_rdata.nxt == CHAIN_NULL) || (steps_inc == CHAIN_W'(NUM_PAGES));
  assign fc        = (pm_rdata.cls > CLS_W'(NUM_CLASSES - 1)) ? CLS_W'(NUM_CLASSES - 1)
                                                              : pm_rdata.cls;
  assign fsz       = 13'd16 << fc;
  assign f_bad     = (hint_r > {3'b0, fsz}) || ((addr_r[11:0] & (fsz[11:0] - 12'd1)) != 12'd0);
  assign f_ref     = pm_rdata.refc - 1'b1;
  assign u_go      = (q != CHAIN_NULL) && (q != {1'b0, pg}) && (steps != CHAIN_W'(NUM_PAGES));
  assign n_obj     = SLOT_NULL >> cls;
  assign thr_last  = ({1'b0, k} + 9'd1) == n_obj;
  assign thr_slot  = SLOT_W'({1'b0, k} << cls);
  assign thr_link  = thr_last ? SLOT_NULL : ({1'b0, thr_slot} + (9'd1 << cls));
  assign first_link = (n_obj > 9'd1) ? (9'd1 << cls) : SLOT_NULL;

  logic out_load;
  assign out_load = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (in_kind == KIND_ALLOC) begin
            if (in_big) state_next = S_OUT;
            else if (in_hp == CHAIN_NULL) state_next = S_NP;
            else state_next = S_WALK;
          end else begin
            state_next = live[in_pg] ? S_FCHK : S_OUT;
          end
        end
      end
      S_WALK: begin
        if (walk_hit) state_next = S_POP;
        else if (walk_end) state_next = S_NP;
      end
      S_POP:    state_next = S_OUT;
      S_NP:     state_next = (fpc == '0) ? S_OUT : S_NP_RD;
      S_NP_RD:  state_next = S_THREAD;
      S_THREAD: if (thr_last) state_next = S_OUT;
      S_FCHK: begin
        if (f_bad || f_ref != '0) state_next = S_OUT;
        else state_next = S_UNLINK;
      end
      S_UNLINK: state_next = u_go ? S_UWAIT : S_OUT;
      S_UWAIT:  state_next = S_UNLINK;
      S_OUT:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cls_next = cls; pg_next = pg; steps_next = steps; pw_next = pw; prevw_next = prevw;
    k_next = k; stk_idx_next = stk_idx; q_next = q; prev_next = prev; nextp_next = nextp;
    addr_r_next = addr_r; hint_r_next = hint_r;
    res_st_next = res_st; res_addr_next = res_addr; res_cls_next = res_cls;
    pm_we = 1'b0; pm_waddr = pg; pm_wdata = pw; pm_raddr = pg;
    ob_we = 1'b0; ob_waddr = {pg, thr_slot}; ob_wdata = thr_link; ob_raddr = {pg, pw.head[7:0]};
    sk_we = 1'b0; sk_waddr = fpc[PAGE_W-1:0]; sk_wdata = pg; sk_raddr = stk_idx;
    head_we = 1'b0; head_wdata = nextp; live_set = 1'b0; live_clr = 1'b0; live_idx = pg;
    push = 1'b0; pop = 1'b0;
    unique case (state)
      S_IDLE: begin
        addr_r_next = in_addr;
        hint_r_next = in_hint;
        steps_next  = '0;
        if (in_kind == KIND_ALLOC) begin
          cls_next = in_big ? '0 : in_cls;
          pg_next  = in_hp[PAGE_W-1:0];
          pm_raddr = in_hp[PAGE_W-1:0];
          res_st_next = STAT_TOO_LARGE; res_addr_next = '0; res_cls_next = '0;
        end else begin
          pg_next  = in_pg;
          pm_raddr = in_pg;
          res_st_next = STAT_BAD_ADDR; res_addr_next = '0; res_cls_next = '0;
        end
      end
      S_WALK: begin
        pw_next    = pm_rdata;
        steps_next = steps_inc;
        ob_raddr   = {pg, pm_rdata.head[7:0]};
        pg_next    = walk_hit ? pg : pm_rdata.nxt[PAGE_W-1:0];
        pm_raddr   = pm_rdata.nxt[PAGE_W-1:0];
      end
      S_POP: begin
        pm_we    = 1'b1;
        pm_wdata = '{cls: pw.cls, refc: pw.refc + 1'b1, head: ob_rdata, nxt: pw.nxt};
        res_st_next = STAT_OK;
        res_addr_next = {pg, pw.head[7:0], 4'b0};
        res_cls_next = cls;
      end
      S_NP: begin
        res_st_next = STAT_NO_MEM; res_addr_next = '0; res_cls_next = cls;
        // stack top is read here so it lands in S_NP_RD
        sk_raddr = PAGE_W'(fpc - 1'b1);
        if (fpc != '0) begin
          pop = 1'b1;
          stk_idx_next = PAGE_W'(fpc - 1'b1);
        end
      end
      S_NP_RD: begin
        pg_next = stk_v[stk_idx] ? sk_rdata : stk_idx;
        k_next  = '0;
      end
      S_THREAD: begin
        ob_we  = 1'b1;
        k_next = k + 1'b1;
        if (thr_last) begin
          pm_we    = 1'b1;
          pm_wdata = '{cls: cls, refc: 9'd1, head: first_link, nxt: heads[cls]};
          head_we  = 1'b1;
          head_wdata = {1'b0, pg};
          live_set = 1'b1;
          res_st_next = STAT_OK;
          res_addr_next = {pg, 12'b0};
          res_cls_next = cls;
        end
      end
      S_FCHK: begin
        if (!f_bad) begin
          ob_we    = 1'b1;
          ob_waddr = {pg, addr_r[11:4]};
          ob_wdata = pm_rdata.head;
          pm_we    = 1'b1;
          pm_wdata = '{cls: pm_rdata.cls, refc: f_ref, head: {1'b0, addr_r[11:4]},
                       nxt: pm_rdata.nxt};
          res_st_next = STAT_OK; res_addr_next = '0; res_cls_next = fc;
        end
        cls_next   = fc;
        nextp_next = pm_rdata.nxt;
        prev_next  = CHAIN_NULL;
        q_next     = heads[fc];
        steps_next = '0;
      end
      S_UNLINK: begin
        pm_raddr = q[PAGE_W-1:0];
        if (!u_go) begin
          if (q == {1'b0, pg}) begin
            if (prev == CHAIN_NULL) begin
              head_we = 1'b1;
            end else begin
              pm_we    = 1'b1;
              pm_waddr = prev[PAGE_W-1:0];
              pm_wdata = '{cls: prevw.cls, refc: prevw.refc, head: prevw.head, nxt: nextp};
            end
          end
          live_clr = 1'b1;
          if (fpc < CHAIN_W'(NUM_PAGES)) begin
            sk_we = 1'b1;
            push  = 1'b1;
          end
        end
      end
      S_UWAIT: begin
        prev_next  = q;
        prevw_next = pm_rdata;
        q_next     = pm_rdata.nxt;
        steps_next = steps_inc;
      end
      S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fpc      <= CHAIN_W'(NUM_PAGES);
      live     <= '0;
      stk_v    <= '0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) heads[i] <= CHAIN_NULL;
    end else begin
      state <= state_next;
      if (pop) fpc <= fpc - 1'b1;
      else if (push) fpc <= fpc + 1'b1;
      if (push) stk_v[fpc[PAGE_W-1:0]] <= 1'b1;
      if (live_set) live[live_idx] <= 1'b1;
      else if (live_clr) live[live_idx] <= 1'b0;
      if (head_we) heads[cls] <= head_wdata;
      if (state == S_OUT && out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cls <= cls_next; pg <= pg_next; steps <= steps_next; pw <= pw_next; prevw <= prevw_next;
    k <= k_next; stk_idx <= stk_idx_next; q <= q_next; prev <= prev_next;
    nextp <= nextp_next; addr_r <= addr_r_next; hint_r <= hint_r_next;
    res_st <= res_st_next; res_addr <= res_addr_next; res_cls <= res_cls_next;
    if (state == S_OUT && out_load) m_tdata <= {res_cls, res_addr, res_st};
  end

  `SCBA_ASSERT(a_fpc_range, fpc <= CHAIN_W'(NUM_PAGES), "free page count out of range")
  `SCBA_ASSERT(a_thr_range, state == S_THREAD |-> ({1'b0, k} < n_obj), "thread index overrun")
  `SCBA_ASSERT(a_out_hold, (state == S_OUT && !out_load) |=> state == S_OUT, "result lost")
  `SCBA_ASSERT(a_no_pop_empty, pop |-> fpc != '0, "pop from empty page stack")
  `SCBA_ASSERT_RST(a_rst_idle, rst |=> state == S_IDLE && !m_tvalid, "reset not idle")
endmodule

>>> dv/testbench.sv
// Self-checking testbench for the size-class bucket allocator.
`timescale 1ns / 1ps
module testbench
  import scba_pkg::*;
;
  localparam int PAGES = 64;
  localparam int SLOTS = 256;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic        kind;
    logic [15:0] len;
    logic [17:0] addr;
    logic [15:0] hint;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [17:0] obj_addr;
    logic [3:0]  cls;
  } grant_t;

  typedef struct {
    req_t   req;
    logic   known;
    grant_t exp;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  size_class_bucket_allocator_top DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // allocator shadow state
  logic [5:0] stk [PAGES];
  int         stk_cnt;
  logic       live [PAGES];
  logic [3:0] pcls [PAGES];
  logic [8:0] refc [PAGES];
  logic [8:0] fhead [PAGES];
  logic [6:0] cnext [PAGES];
  logic [6:0] chead [NUM_CLASSES];
  logic [8:0] olink [PAGES*SLOTS];

  grant_t grant_q[$];
  int     errors = 0;
  int     n_alloc_ok = 0, n_free_ok = 0, n_nomem = 0, n_bad = 0, n_big = 0;
  logic [17:0] owned[$];

  int sender_idle = 19, receiver_idle = 69;
  bit hold_off = 1'b0;
  int quiet = 0;

  function automatic void allocator_reset();
    for (int i = 0; i < PAGES; i++) begin
      stk[i] = i[5:0];
      live[i] = 1'b0;
    end
    stk_cnt = PAGES;
    for (int i = 0; i < NUM_CLASSES; i++) chead[i] = 7'(PAGES);
  endfunction

  function automatic grant_t allocate(input logic [15:0] len);
    grant_t g;
    int c, p, steps, n;
    logic [8:0] h;
    c = 0;
    steps = 0;
    g = '{STAT_OK, 18'd0, 4'd0};
    if (len > 16'd4096) begin
      g.status = STAT_TOO_LARGE;
      return g;
    end
    while ((16 << c) < len) c++;
    p = chead[c];
    while (p < PAGES && steps < PAGES) begin
      if (fhead[p] < SLOTS) break;
      p = cnext[p];
      steps++;
    end
    if (!(p < PAGES && steps < PAGES)) begin
      if (stk_cnt == 0) begin
        g.status = STAT_NO_MEM;
        g.cls = 4'(c);
        return g;
      end
      stk_cnt--;
      p = stk[stk_cnt];
      n = SLOTS >> c;
      for (int k = 0; k < n; k++)
        olink[p*SLOTS + (k << c)] = (k + 1 < n) ? 9'((k << c) + (1 << c)) : 9'(SLOTS);
      fhead[p] = '0;
      refc[p] = '0;
      pcls[p] = 4'(c);
      live[p] = 1'b1;
      cnext[p] = chead[c];
      chead[c] = 7'(p);
    end
    h = fhead[p];
    fhead[p] = olink[p*SLOTS + h];
    refc[p] = refc[p] + 9'd1;
    g.obj_addr = 18'(p * 4096 + h * 16);
    g.cls = 4'(c);
    return g;
  endfunction

  function automatic grant_t release_obj(input logic [17:0] addr, input logic [15:0] hint);
    grant_t g;
    int p, off, c, sz, slot, prev, q, steps;
    g = '{STAT_BAD_ADDR, 18'd0, 4'd0};
    p = addr / 4096;
    off = addr % 4096;
    if (p >= PAGES || !live[p]) return g;
    c = pcls[p];
    if (c >= NUM_CLASSES) c = NUM_CLASSES - 1;
    sz = 16 << c;
    if (hint > sz || (off % sz) != 0) return g;
    slot = off / 16;
    olink[p*SLOTS + slot] = fhead[p];
    fhead[p] = 9'(slot);
    refc[p] = refc[p] - 9'd1;
    if (refc[p] == 0) begin
      prev = PAGES;
      q = chead[c];
      steps = 0;
      while (q < PAGES && q != p && steps < PAGES) begin
        prev = q;
        q = cnext[q];
        steps++;
      end
      if (q == p) begin
        if (prev == PAGES) chead[c] = cnext[p];
        else cnext[prev] = cnext[p];
      end
      live[p] = 1'b0;
      if (stk_cnt < PAGES) begin
        stk[stk_cnt] = 6'(p);
        stk_cnt++;
      end
    end
    g.status = STAT_OK;
    g.cls = 4'(c);
    return g;
  endfunction

  function automatic grant_t serve(input req_t r);
    grant_t g;
    g = (r.kind == KIND_ALLOC) ? allocate(r.len) : release_obj(r.addr, r.hint);
    case (g.status)
      STAT_OK: if (r.kind == KIND_ALLOC) begin
        n_alloc_ok++;
        owned.push_back(g.obj_addr);
      end else n_free_ok++;
      STAT_NO_MEM: n_nomem++;
      STAT_BAD_ADDR: n_bad++;
      default: n_big++;
    endcase
    return g;
  endfunction

  // valid stays up after an accept until the next idle cycle or a drain
  task automatic offer(input req_t r, input logic known, input grant_t typed);
    grant_t g;
    while ($urandom_range(99) < sender_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.kind;
    s_tdata <= {6'd0, r.hint, r.addr, r.len};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    g = serve(r);
    if (known && g != typed) begin
      $error("typed row disagrees with prediction: %h vs %h", typed, g);
      errors++;
    end
    grant_q.push_back(known ? typed : g);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic req_t mk_alloc(input int len);
    return '{1'b0, 16'(len), 18'd0, 16'd0};
  endfunction

  function automatic req_t mk_free(input int addr, input int hint);
    return '{1'b1, 16'd0, 18'(addr), 16'(hint)};
  endfunction

  // pick a request: mostly allocations and frees of held objects, some noise
  function automatic req_t pick();
    int sel, idx, len;
    logic [17:0] a;
    sel = $urandom_range(99);
    if (sel < 45 || owned.size() == 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(65535) :
            ($urandom_range(3) == 0) ? $urandom_range(4096) : $urandom_range(300);
      return mk_alloc(len);
    end
    if (sel < 88) begin
      idx = $urandom_range(owned.size() - 1);
      a = owned[idx];
      owned.delete(idx);
      return mk_free(a, $urandom_range(3) == 0 ? $urandom_range(64) : 0);
    end
    return '{1'b1, 16'($urandom), 18'($urandom), 16'($urandom)};
  endfunction

  function automatic req_t pick_free();
    logic [17:0] a;
    a = owned.pop_back();
    return mk_free(a, 0);
  endfunction

  // output checker
  always @(posedge clk) begin
    grant_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = grant_t'({m_tdata[1:0], m_tdata[19:2], m_tdata[23:20]});
      if (grant_q.size() == 0) begin
        $error("result with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        want = grant_q.pop_front();
        if (got.status != want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          errors++;
        end
        if (got.obj_addr != want.obj_addr) begin
          $error("object_address expected %h actual %h", want.obj_addr, got.obj_addr);
          errors++;
        end
        if (got.cls != want.cls) begin
          $error("granted_class expected %0d actual %0d", want.cls, got.cls);
          errors++;
        end
      end
    end
  end

  // receiver stall generator
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= receiver_idle);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  row_t rows[$];

  initial begin
    allocator_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{mk_alloc(4097), 1'b1, '{STAT_TOO_LARGE, 18'd0, 4'd0}});
    rows.push_back('{mk_alloc(65535), 1'b1, '{STAT_TOO_LARGE, 18'd0, 4'd0}});
    rows.push_back('{mk_alloc(0), 1'b1, '{STAT_OK, 18'h3F000, 4'd0}});
    rows.push_back('{mk_alloc(16), 1'b1, '{STAT_OK, 18'h3F010, 4'd0}});
    rows.push_back('{mk_alloc(17), 1'b1, '{STAT_OK, 18'h3E000, 4'd1}});
    rows.push_back('{mk_alloc(4096), 1'b1, '{STAT_OK, 18'h3D000, 4'd8}});
    rows.push_back('{mk_free(18'h3FFFF, 0), 1'b1, '{STAT_BAD_ADDR, 18'd0, 4'd0}});
    rows.push_back('{mk_free(18'h00000, 0), 1'b1, '{STAT_BAD_ADDR, 18'd0, 4'd0}});
    rows.push_back('{mk_free(18'h3E010, 0), 1'b1, '{STAT_BAD_ADDR, 18'd0, 4'd0}});
    rows.push_back('{mk_free(18'h3E000, 33), 1'b1, '{STAT_BAD_ADDR, 18'd0, 4'd0}});
    rows.push_back('{mk_free(18'h3E000, 65535), 1'b1, '{STAT_BAD_ADDR, 18'd0, 4'd0}});
    rows.push_back('{mk_free(18'h3E000, 32), 1'b1, '{STAT_OK, 18'd0, 4'd1}});
    rows.push_back('{mk_free(18'h3D000, 4096), 1'b1, '{STAT_OK, 18'd0, 4'd8}});
    rows.push_back('{mk_free(18'h3F000, 0), 1'b0, '{STAT_OK, 18'd0, 4'd0}});
    rows.push_back('{mk_free(18'h3F000, 0), 1'b0, '{STAT_OK, 18'd0, 4'd0}});
    rows.push_back('{mk_alloc(100), 1'b0, '{STAT_OK, 18'd0, 4'd0}});
    rows.push_back('{mk_alloc(2049), 1'b0, '{STAT_OK, 18'd0, 4'd0}});
    foreach (rows[i]) offer(rows[i].req, rows[i].known, rows[i].exp);
    drain();

    // fill the pool to reach out-of-memory, then give it all back
    repeat (70) offer(mk_alloc(4000), 1'b0, '0);
    offer(mk_alloc(1), 1'b0, '0);
    drain();
    while (owned.size() != 0) offer(pick_free(), 1'b0, '0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin sender_idle = 69; receiver_idle = 19; end
      if (ph == 2) begin sender_idle = 0; receiver_idle = 0; end
      for (int i = 0; i < 370; i++) begin
        if (ph == 1 && i == 100) fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
        if (i == 200) drain();
        offer(pick(), 1'b0, '0);
      end
      drain();
    end

    $display("Covered %0d allocations, %0d frees, %0d out-of-memory, %0d bad frees,",
             n_alloc_ok, n_free_ok, n_nomem, n_bad);
    $display("and %0d oversize requests across three stall patterns.", n_big);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
